// ----- hdl/agte_pkg.sv -----
package agte_pkg;

   localparam int MAX_GAPS_DEFAULT      = 64;
   localparam int POSITION_BITS_DEFAULT = 16;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_QUERY  = 3'd2;
   localparam logic [2:0] OP_INSERT = 3'd3;
   localparam logic [2:0] OP_REMOVE = 3'd4;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_IGNORED  = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_CHECK,
      S_WRITE,
      S_FINAL,
      S_RESP
   } state_type;

   // How an insert reshapes the list.
   typedef enum logic [1:0] {
      K_GROW0,
      K_GAP,
      K_NEW
   } kind_type;

endpackage

// ----- hdl/agte_table_ram.sv -----
module agte_table_ram #(
   parameter int DEPTH = agte_pkg::MAX_GAPS_DEFAULT,
   parameter int DW    = 2 * agte_pkg::POSITION_BITS_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/alignment_gap_table_engine_unit.sv -----
// Gap table engine for one alignment row: clear and append need no pass over the table.
// Query makes one pass over the entries, remove two and insert up to three; every pass
// walks the table RAM one entry per cycle on its single read port and single write port.
// One item is worked on at a time, and a new item is taken while the previous result
// still waits. Synchronous reset clears the entry count, data_length and all handshake
// state; the table contents are not cleared.
module alignment_gap_table_engine_unit #(
   parameter int MAX_GAPS      = agte_pkg::MAX_GAPS_DEFAULT,
   parameter int POSITION_BITS = agte_pkg::POSITION_BITS_DEFAULT,
   parameter int AW     = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1,
   parameter int CW     = $clog2(MAX_GAPS + 1),
   parameter int IN_DW  = ((2 * POSITION_BITS + 7) / 8) * 8,
   parameter int OUT_DW = ((POSITION_BITS + 1 + CW + 2 + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration: data_length.
   input  logic                     csr_wr_en,
   input  logic [POSITION_BITS-1:0] csr_wr_data,
   // Request item.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_DW-1:0]         req_tdata,  // position, count, zero fill
   input  logic [3:0]               req_tuser,  // op[2:0], allow_gap_at_position
   // Result item.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_DW-1:0]        rsp_tdata,  // ungapped_position, gaps_in_use, status, fill
   output logic [0:0]               rsp_tuser   // is_gap
);

   localparam int PB  = POSITION_BITS;
   localparam int SW  = PB + CW + 1;   // sums of up to MAX_GAPS + 1 lengths
   localparam int UGW = PB + 1;

   // Item and configuration registers.
   agte_pkg::state_type state_ff, state_in;
   agte_pkg::kind_type  kind_ff;
   logic [2:0]    op_ff;
   logic [PB-1:0] pos_ff, cnt_ff, dlen_ff;
   logic          allow_ff;
   logic [CW-1:0] count_ff;

   // Walk control.
   logic [CW-1:0] step_ff, wn_ff, at_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          pv_ff;

   // First-pass accumulators.
   logic [SW-1:0] rl_ff, tot_ff, g0_gl_ff, g1_gl_ff, gu_ff;
   logic          rs_stop_ff, g0_dec_ff, g0_val_ff, g1_dec_ff, g1_val_ff;
   logic          u_stop_ff, at_found_ff, off0z_ff, ovf_ff;

   // Pending result.
   logic           res_gap_ff;
   logic [UGW-1:0] res_ung_ff;
   logic [1:0]     res_st_ff;

   // Result register.
   logic           rsp_valid_ff, rsp_gap_ff;
   logic [UGW-1:0] rsp_ung_ff;
   logic [CW-1:0]  rsp_use_ff;
   logic [1:0]     rsp_st_ff;

   // RAM ports.
   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [2*PB-1:0] wr_data, rd_data;

   agte_table_ram #(
      .DEPTH (MAX_GAPS),
      .DW    (2 * PB),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request fields.
   logic [2:0]    req_op;
   logic [PB-1:0] req_pos, req_cnt;
   logic          req_accept;

   assign req_op     = req_tuser[2:0];
   assign req_pos    = req_tdata[PB-1:0];
   assign req_cnt    = req_tdata[2*PB-1:PB];
   assign req_tready = (state_ff == agte_pkg::S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // The entry that arrives from the RAM this cycle.
   logic [PB-1:0] e_off, e_len;
   logic [PB:0]   e_end;
   logic [CW-1:0] e_idx;
   logic [PB-1:0] pos_m1;

   assign e_off  = rd_data[PB-1:0];
   assign e_len  = rd_data[2*PB-1:PB];
   assign e_end  = {1'b0, e_off} + {1'b0, e_len};
   assign e_idx  = CW'(rd_addr_ff);
   assign pos_m1 = pos_ff - PB'(1);

   logic scan_state, scan_last, backward;
   assign scan_state = (state_ff == agte_pkg::S_SCAN) || (state_ff == agte_pkg::S_CHECK) ||
                       (state_ff == agte_pkg::S_WRITE);
   assign scan_last  = (step_ff == count_ff);
   assign backward   = (state_ff == agte_pkg::S_WRITE) && (op_ff == agte_pkg::OP_INSERT);
   assign rd_en      = scan_state && !scan_last;
   assign rd_addr    = backward ? AW'(count_ff - step_ff - CW'(1)) : AW'(step_ff);

   // Insert: new shape of an existing entry, one bit wider to catch overflow.
   logic [PB:0] xf_off, xf_len;
   logic        xf_ovf;

   always_comb begin
      xf_off = {1'b0, e_off};
      xf_len = {1'b0, e_len};
      case (kind_ff)
         agte_pkg::K_GROW0: begin
            if (e_idx == '0) begin
               xf_len = {1'b0, e_len} + {1'b0, cnt_ff};
            end else begin
               xf_off = {1'b0, e_off} + {1'b0, cnt_ff};
            end
         end
         agte_pkg::K_GAP: begin
            if (pos_ff >= e_off) begin
               if ({1'b0, pos_ff} <= e_end) begin
                  xf_len = {1'b0, e_len} + {1'b0, cnt_ff};
               end
            end else begin
               xf_off = {1'b0, e_off} + {1'b0, cnt_ff};
            end
         end
         agte_pkg::K_NEW: begin
            if (e_idx >= at_ff) begin
               xf_off = {1'b0, e_off} + {1'b0, cnt_ff};
            end
         end
         default: begin
         end
      endcase
      xf_ovf = xf_off[PB] || xf_len[PB];
   end

   // Remove: trim, drop or shift the entry against the span [pos, pos + count).
   logic [PB:0]   rm_endp;
   logic [PB-1:0] rm_off, rm_len;
   logic          rm_keep;

   assign rm_endp = {1'b0, pos_ff} + {1'b0, cnt_ff};

   always_comb begin
      rm_off  = e_off;
      rm_len  = e_len;
      rm_keep = 1'b1;
      if (e_end < {1'b0, pos_ff}) begin
         rm_keep = 1'b1;
      end else if (e_end <= rm_endp) begin
         if (e_off >= pos_ff) begin
            rm_keep = 1'b0;
         end else begin
            rm_len = pos_ff - e_off;
         end
      end else if (e_off < pos_ff) begin
         rm_len = e_len - cnt_ff;
      end else if ({1'b0, e_off} < rm_endp) begin
         rm_len = PB'(e_end - rm_endp);
         rm_off = pos_ff;
      end else begin
         rm_off = e_off - cnt_ff;
      end
   end

   // Gap tests once the first pass is over. A test not settled by an entry falls
   // back on the row end: data_length for a query, and for an insert the row span
   // less all lengths, which is compared here without going negative.
   logic [SW-1:0] base_w, extra_w;
   logic          g0_fin, g1_fin, ovf_now;
   logic [CW-1:0] at_sel;

   assign base_w  = (op_ff == agte_pkg::OP_QUERY) ? SW'(dlen_ff) : rl_ff;
   assign extra_w = (op_ff == agte_pkg::OP_QUERY) ? '0 : tot_ff;
   assign g0_fin  = g0_dec_ff ? g0_val_ff : (base_w + g0_gl_ff <= SW'(pos_ff) + extra_w);
   assign g1_fin  = g1_dec_ff ? g1_val_ff : (base_w + g1_gl_ff <= SW'(pos_m1) + extra_w);
   assign ovf_now = ovf_ff || (pv_ff && xf_ovf);
   assign at_sel  = at_found_ff ? at_ff : count_ff;

   // Write port: append, rewrite pass, and the new entry after an insert pass.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(count_ff);
      wr_data = {req_cnt, req_pos};
      case (state_ff)
         agte_pkg::S_IDLE: begin
            wr_en = req_accept && (req_op == agte_pkg::OP_APPEND) &&
                    (count_ff < CW'(MAX_GAPS));
         end
         agte_pkg::S_WRITE: begin
            if (op_ff == agte_pkg::OP_INSERT) begin
               wr_en   = pv_ff;
               wr_addr = ((kind_ff == agte_pkg::K_NEW) && (e_idx >= at_ff)) ?
                         AW'(e_idx + CW'(1)) : AW'(e_idx);
               wr_data = {xf_len[PB-1:0], xf_off[PB-1:0]};
            end else begin
               wr_en   = pv_ff && rm_keep;
               wr_addr = AW'(wn_ff);
               wr_data = {rm_len, rm_off};
            end
         end
         agte_pkg::S_FINAL: begin
            wr_en   = 1'b1;
            wr_addr = AW'(at_ff);
            wr_data = {cnt_ff, pos_ff};
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         agte_pkg::S_IDLE: begin
            if (req_accept) begin
               if ((req_op == agte_pkg::OP_QUERY) || (req_op == agte_pkg::OP_INSERT) ||
                   (req_op == agte_pkg::OP_REMOVE)) begin
                  state_in = agte_pkg::S_SCAN;
               end else begin
                  state_in = agte_pkg::S_RESP;
               end
            end
         end
         agte_pkg::S_SCAN: begin
            if (scan_last) begin
               state_in = agte_pkg::S_DECIDE;
            end
         end
         agte_pkg::S_DECIDE: begin
            state_in = agte_pkg::S_RESP;
            if (op_ff == agte_pkg::OP_REMOVE) begin
               if (SW'(pos_ff) <= rl_ff) begin
                  state_in = agte_pkg::S_WRITE;
               end
            end else if (op_ff == agte_pkg::OP_INSERT && SW'(pos_ff) < rl_ff) begin
               if (pos_ff == '0) begin
                  if (cnt_ff != '0 && ((count_ff != '0 && off0z_ff) ||
                                       count_ff < CW'(MAX_GAPS))) begin
                     state_in = agte_pkg::S_CHECK;
                  end
               end else if (g0_fin || g1_fin || count_ff < CW'(MAX_GAPS)) begin
                  state_in = agte_pkg::S_CHECK;
               end
            end
         end
         agte_pkg::S_CHECK: begin
            if (scan_last) begin
               state_in = ovf_now ? agte_pkg::S_RESP : agte_pkg::S_WRITE;
            end
         end
         agte_pkg::S_WRITE: begin
            if (scan_last) begin
               state_in = ((op_ff == agte_pkg::OP_INSERT) && (kind_ff == agte_pkg::K_NEW)) ?
                          agte_pkg::S_FINAL : agte_pkg::S_RESP;
            end
         end
         agte_pkg::S_FINAL: begin
            state_in = agte_pkg::S_RESP;
         end
         agte_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = agte_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = agte_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= agte_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dlen_ff <= csr_wr_data;
         end
         if (state_ff == agte_pkg::S_IDLE && req_accept) begin
            if (req_op == agte_pkg::OP_CLEAR) begin
               count_ff <= '0;
            end else if (req_op == agte_pkg::OP_APPEND && count_ff < CW'(MAX_GAPS)) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (state_ff == agte_pkg::S_WRITE && scan_last && op_ff == agte_pkg::OP_REMOVE) begin
            count_ff <= wn_ff + CW'(pv_ff && rm_keep);
         end
         if (state_ff == agte_pkg::S_FINAL) begin
            count_ff <= count_ff + CW'(1);
         end
         if (state_ff == agte_pkg::S_RESP && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk and datapath registers.
   always_ff @(posedge clock) begin
      if (scan_state) begin
         step_ff    <= scan_last ? '0 : step_ff + CW'(1);
         pv_ff      <= rd_en;
         rd_addr_ff <= rd_addr;
      end else begin
         step_ff <= '0;
         pv_ff   <= 1'b0;
      end

      case (state_ff)
         agte_pkg::S_IDLE: begin
            op_ff       <= req_op;
            pos_ff      <= req_pos;
            cnt_ff      <= req_cnt;
            allow_ff    <= req_tuser[3];
            rl_ff       <= SW'(dlen_ff);
            tot_ff      <= '0;
            g0_gl_ff    <= '0;
            g1_gl_ff    <= '0;
            gu_ff       <= '0;
            rs_stop_ff  <= 1'b0;
            g0_dec_ff   <= 1'b0;
            g1_dec_ff   <= 1'b0;
            g0_val_ff   <= 1'b0;
            g1_val_ff   <= 1'b0;
            u_stop_ff   <= 1'b0;
            at_found_ff <= 1'b0;
            at_ff       <= '0;
            off0z_ff    <= 1'b0;
            ovf_ff      <= 1'b0;
            wn_ff       <= '0;
            res_gap_ff  <= 1'b0;
            res_ung_ff  <= '0;
            res_st_ff   <= agte_pkg::STATUS_DONE;
            if (req_op == agte_pkg::OP_APPEND && count_ff >= CW'(MAX_GAPS)) begin
               res_st_ff <= agte_pkg::STATUS_FULL;
            end else if (req_op != agte_pkg::OP_CLEAR && req_op != agte_pkg::OP_APPEND &&
                         req_op != agte_pkg::OP_QUERY && req_op != agte_pkg::OP_INSERT &&
                         req_op != agte_pkg::OP_REMOVE) begin
               res_st_ff <= agte_pkg::STATUS_IGNORED;
            end
         end
         agte_pkg::S_SCAN: begin
            if (pv_ff) begin
               // Row span: stops at the first entry past the span so far.
               if (!rs_stop_ff) begin
                  if (SW'(e_off) > rl_ff) begin
                     rs_stop_ff <= 1'b1;
                  end else begin
                     rl_ff <= rl_ff + SW'(e_len);
                  end
               end
               tot_ff <= tot_ff + SW'(e_len);
               if (!g0_dec_ff) begin
                  if (e_off <= pos_ff && {1'b0, pos_ff} < e_end) begin
                     g0_dec_ff <= 1'b1;
                     g0_val_ff <= 1'b1;
                  end else if (pos_ff < e_off) begin
                     g0_dec_ff <= 1'b1;
                  end else begin
                     g0_gl_ff <= g0_gl_ff + SW'(e_len);
                  end
               end
               if (!g1_dec_ff) begin
                  if (e_off <= pos_m1 && {1'b0, pos_m1} < e_end) begin
                     g1_dec_ff <= 1'b1;
                     g1_val_ff <= 1'b1;
                  end else if (pos_m1 < e_off) begin
                     g1_dec_ff <= 1'b1;
                  end else begin
                     g1_gl_ff <= g1_gl_ff + SW'(e_len);
                  end
               end
               if (!at_found_ff && {1'b0, pos_ff} <= e_end) begin
                  at_found_ff <= 1'b1;
                  at_ff       <= e_idx;
               end
               // Gap columns before the position, clipped to it when allowed.
               if (!u_stop_ff) begin
                  if (e_off >= pos_ff) begin
                     u_stop_ff <= 1'b1;
                  end else if (allow_ff && e_end >= {1'b0, pos_ff}) begin
                     gu_ff <= gu_ff + SW'(pos_ff - e_off);
                  end else begin
                     gu_ff <= gu_ff + SW'(e_len);
                  end
               end
               if (e_idx == '0) begin
                  off0z_ff <= (e_off == '0);
               end
            end
         end
         agte_pkg::S_DECIDE: begin
            case (op_ff)
               agte_pkg::OP_QUERY: begin
                  res_gap_ff <= g0_fin;
                  if ((g0_fin && !allow_ff) || gu_ff > SW'(pos_ff)) begin
                     res_ung_ff <= '1;
                  end else begin
                     res_ung_ff <= UGW'(SW'(pos_ff) - gu_ff);
                  end
               end
               agte_pkg::OP_REMOVE: begin
                  if (SW'(pos_ff) > rl_ff) begin
                     res_st_ff <= agte_pkg::STATUS_IGNORED;
                  end
               end
               agte_pkg::OP_INSERT: begin
                  if (SW'(pos_ff) >= rl_ff) begin
                     res_st_ff <= agte_pkg::STATUS_IGNORED;
                  end else if (pos_ff == '0) begin
                     if (count_ff != '0 && off0z_ff) begin
                        kind_ff <= agte_pkg::K_GROW0;
                     end else if (cnt_ff != '0 && count_ff >= CW'(MAX_GAPS)) begin
                        res_st_ff <= agte_pkg::STATUS_FULL;
                     end else begin
                        kind_ff <= agte_pkg::K_NEW;
                        at_ff   <= '0;
                     end
                  end else if (g0_fin || g1_fin) begin
                     kind_ff <= agte_pkg::K_GAP;
                  end else if (count_ff >= CW'(MAX_GAPS)) begin
                     res_st_ff <= agte_pkg::STATUS_FULL;
                  end else begin
                     kind_ff <= agte_pkg::K_NEW;
                     at_ff   <= at_sel;
                  end
               end
               default: begin
               end
            endcase
         end
         agte_pkg::S_CHECK: begin
            ovf_ff <= ovf_now;
            if (scan_last && ovf_now) begin
               res_st_ff <= agte_pkg::STATUS_OVERFLOW;
            end
         end
         agte_pkg::S_WRITE: begin
            if (pv_ff && rm_keep && op_ff == agte_pkg::OP_REMOVE) begin
               wn_ff <= wn_ff + CW'(1);
            end
         end
         agte_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_gap_ff <= res_gap_ff;
               rsp_ung_ff <= res_ung_ff;
               rsp_use_ff <= count_ff;
               rsp_st_ff  <= res_st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'({rsp_st_ff, rsp_use_ff, rsp_ung_ff});
   assign rsp_tuser  = rsp_gap_ff;

endmodule
